[design/lifl_pkg.sv]
// Shared types, widths, register codes and reset values of the LIF neuron layer.
// Used by lifl_mem, lifl_alu and lif_neuron_layer_unit; depends on nothing.
`timescale 1ns / 1ps

package lifl_pkg;

  // Default layer size
  localparam int NEURONS_DEF = 32;

  // Field widths
  localparam int IDX_W  = 5;
  localparam int V_W    = 16;
  localparam int ACC_W  = 24;
  localparam int REF_W  = 8;
  localparam int CNT_W  = 16;
  localparam int GAIN_W = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values
  localparam logic signed [V_W-1:0] REST_RST  = -16'sd16640;
  localparam logic signed [V_W-1:0] THR_RST   = -16'sd14080;
  localparam logic signed [V_W-1:0] AFTER_RST = -16'sd17920;
  localparam logic [GAIN_W-1:0]     GAIN_RST  = 16'd1638;
  localparam logic [REF_W-1:0]      REFR_RST  = 8'd3;

  // Accumulator saturation limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;

  // Opcodes
  localparam logic OP_INJECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register indexes (word address bits)
  typedef enum logic [2:0] {
    REG_REST  = 3'd0,
    REG_THR   = 3'd1,
    REG_AFTER = 3'd2,
    REG_GAIN  = 3'd3,
    REG_REFR  = 3'd4
  } reg_idx_e;

  // One neuron's stored state
  typedef struct packed {
    logic signed [V_W-1:0]   v;
    logic signed [ACC_W-1:0] acc;
    logic [REF_W-1:0]        refr;
    logic [CNT_W-1:0]        cnt;
  } row_t;

  localparam row_t ROW_RST = '{v: REST_RST, acc: '0, refr: '0, cnt: '0};

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [V_W-1:0] rest;
    logic signed [V_W-1:0] thr;
    logic signed [V_W-1:0] after;
    logic [GAIN_W-1:0]     gain;
    logic [REF_W-1:0]      refr;
  } cfg_t;

  // Rows and flags produced by the shared datapath
  typedef struct packed {
    row_t tick_row;
    row_t refr_row;
    row_t inj_row;
    logic fire;
  } upd_t;

endpackage

[design/lifl_mem.sv]
// Neuron state memory: one row per neuron, registered read, valid bit per row.
// Depends on lifl_pkg; a row never written since reset reads as the reset row.
`timescale 1ns / 1ps

module lifl_mem #(
  parameter int NEURONS = lifl_pkg::NEURONS_DEF,
  parameter int IW      = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IW-1:0]    rd_addr_i,
  output lifl_pkg::row_t   rd_row_o,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_addr_i,
  input  lifl_pkg::row_t   wr_row_i
);

  lifl_pkg::row_t     mem [NEURONS];
  lifl_pkg::row_t     rd_q;
  logic               rd_vld_q;
  logic [NEURONS-1:0] valid_q;

  // Write and read the row array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Track written rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Substitute the reset row for rows never written
  assign rd_row_o = rd_vld_q ? rd_q : lifl_pkg::ROW_RST;

endmodule

[design/lifl_alu.sv]
// Shared neuron datapath: leak multiply (registered), voltage update, spike test,
// refractory countdown and saturating inject. Depends on lifl_pkg.
`timescale 1ns / 1ps

module lifl_alu (
  input  logic                                  clk_i,
  input  logic                                  mul_en_i,
  input  lifl_pkg::cfg_t                        cfg_i,
  input  lifl_pkg::row_t                        row_i,
  input  logic signed [lifl_pkg::V_W-1:0]       amount_i,
  output lifl_pkg::upd_t                        upd_o
);

  logic signed [16:0] vdiff;
  logic signed [24:0] drive;
  logic signed [41:0] prod_d;
  logic signed [41:0] prod_q;
  logic signed [25:0] step;
  logic signed [26:0] vsum;
  logic signed [15:0] vnew;
  logic               fire;
  logic signed [24:0] isum;
  logic signed [23:0] inew;
  lifl_pkg::row_t     tick_row;
  lifl_pkg::row_t     refr_row;
  lifl_pkg::row_t     inj_row;

  // Leak drive: acc - (v - rest), then times gain
  assign vdiff  = {row_i.v[15], row_i.v} - {cfg_i.rest[15], cfg_i.rest};
  assign drive  = {row_i.acc[23], row_i.acc} - {{8{vdiff[16]}}, vdiff};
  assign prod_d = drive * $signed({1'b0, cfg_i.gain});

  // Hold product for the update step
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Floor shift, add to voltage, saturate
  assign step = prod_q[41:16];
  assign vsum = {{11{row_i.v[15]}}, row_i.v} + {step[25], step};

  always_comb begin
    if (vsum > 27'sd32767) begin
      vnew = 16'sh7FFF;
    end else if (vsum < -27'sd32768) begin
      vnew = 16'sh8000;
    end else begin
      vnew = vsum[15:0];
    end
  end

  assign fire = vnew >= cfg_i.thr;

  // Row after an integrating step
  always_comb begin
    tick_row.acc = '0;
    if (fire) begin
      tick_row.v    = cfg_i.after;
      tick_row.refr = cfg_i.refr;
      tick_row.cnt  = (&row_i.cnt) ? row_i.cnt : row_i.cnt + 16'd1;
    end else begin
      tick_row.v    = vnew;
      tick_row.refr = row_i.refr;
      tick_row.cnt  = row_i.cnt;
    end
  end

  // Row after a refractory step
  always_comb begin
    refr_row      = row_i;
    refr_row.acc  = '0;
    refr_row.refr = row_i.refr - 8'd1;
  end

  // Saturating inject into the accumulator
  assign isum = {row_i.acc[23], row_i.acc} + {{9{amount_i[15]}}, amount_i};

  always_comb begin
    if (isum > $signed({lifl_pkg::ACC_MAX[23], lifl_pkg::ACC_MAX})) begin
      inew = lifl_pkg::ACC_MAX;
    end else if (isum < $signed({lifl_pkg::ACC_MIN[23], lifl_pkg::ACC_MIN})) begin
      inew = lifl_pkg::ACC_MIN;
    end else begin
      inew = isum[23:0];
    end
  end

  always_comb begin
    inj_row     = row_i;
    inj_row.acc = inew;
  end

  // Gather rows and spike flag
  assign upd_o = '{tick_row: tick_row, refr_row: refr_row, inj_row: inj_row, fire: fire};

endmodule

[design/lif_neuron_layer_unit.sv]
// LIF neuron layer: an inject request is accepted with a row read, then its row is written.
// A tick request walks all neurons through the shared multiply/update unit, a free
// neuron through S_MUL and S_UPD and a refractory neuron through S_MUL only, between
// the accept and the end marker; the walk holds while the output stalls. One request
// is worked at a time.
// Reset (async, active low) restores registers and makes all rows read as rest state.
`timescale 1ns / 1ps

module lif_neuron_layer_unit #(
  parameter int NEURONS = lifl_pkg::NEURONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [4:0]                        target_neuron_i,
  input  logic signed [15:0]                current_amount_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [4:0]                        spiked_neuron_o,
  output logic [15:0]                       spike_total_o,
  output logic                              tick_end_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lifl_pkg::ADDR_W-1:0]       paddr,
  input  logic [lifl_pkg::DATA_W-1:0]       pwdata,
  output logic [lifl_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int IW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INJ,
    S_MUL,
    S_UPD,
    S_END
  } state_e;

  state_e               state_q, state_d;
  logic [IW-1:0]        idx_q, idx_d, idx_nxt;
  logic signed [15:0]   amt_q, amt_d;
  logic                 ov_q, ov_d;
  logic [4:0]           sp_q, sp_d;
  logic [15:0]          tot_q, tot_d;
  logic                 end_q, end_d;

  lifl_pkg::cfg_t       cfg_q;
  lifl_pkg::row_t       row;
  lifl_pkg::row_t       wr_row;
  lifl_pkg::upd_t       upd;
  logic                 rd_en, wr_en, mul_en;
  logic [IW-1:0]        rd_addr;
  logic                 in_acc, out_free, last, tgt_ok, cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest  <= lifl_pkg::REST_RST;
      cfg_q.thr   <= lifl_pkg::THR_RST;
      cfg_q.after <= lifl_pkg::AFTER_RST;
      cfg_q.gain  <= lifl_pkg::GAIN_RST;
      cfg_q.refr  <= lifl_pkg::REFR_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        lifl_pkg::REG_REST:  cfg_q.rest  <= pwdata[15:0];
        lifl_pkg::REG_THR:   cfg_q.thr   <= pwdata[15:0];
        lifl_pkg::REG_AFTER: cfg_q.after <= pwdata[15:0];
        lifl_pkg::REG_GAIN:  cfg_q.gain  <= pwdata[15:0];
        lifl_pkg::REG_REFR:  cfg_q.refr  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[4:2])
      lifl_pkg::REG_REST:  prdata = {{16{cfg_q.rest[15]}}, cfg_q.rest};
      lifl_pkg::REG_THR:   prdata = {{16{cfg_q.thr[15]}}, cfg_q.thr};
      lifl_pkg::REG_AFTER: prdata = {{16{cfg_q.after[15]}}, cfg_q.after};
      lifl_pkg::REG_GAIN:  prdata = {16'd0, cfg_q.gain};
      lifl_pkg::REG_REFR:  prdata = {24'd0, cfg_q.refr};
      default:             prdata = '0;
    endcase
  end

  // Row memory and shared datapath
  lifl_mem #(
    .NEURONS (NEURONS),
    .IW      (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (row),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_row_i  (wr_row)
  );

  lifl_alu u_alu (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .cfg_i    (cfg_q),
    .row_i    (row),
    .amount_i (amt_q),
    .upd_o    (upd)
  );

  // Handshake helpers
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~ov_q | ~out_stall_i;
  assign last       = (idx_q == IW'(NEURONS - 1));
  assign idx_nxt    = idx_q + IW'(1);
  assign tgt_ok     = (int'(target_neuron_i) < NEURONS);

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    amt_d   = amt_q;
    ov_d    = ov_q & ~out_free;
    sp_d    = sp_q;
    tot_d   = tot_q;
    end_d   = end_q;
    rd_en   = 1'b0;
    rd_addr = idx_nxt;
    wr_en   = 1'b0;
    wr_row  = upd.tick_row;
    mul_en  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode_i == lifl_pkg::OP_TICK) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            state_d = S_MUL;
          end else if (tgt_ok) begin
            rd_en   = 1'b1;
            rd_addr = IW'(target_neuron_i);
            idx_d   = IW'(target_neuron_i);
            amt_d   = current_amount_i;
            state_d = S_INJ;
          end
        end
      end
      S_INJ: begin
        wr_en   = 1'b1;
        wr_row  = upd.inj_row;
        state_d = S_IDLE;
      end
      S_MUL: begin
        if (row.refr != '0) begin
          // count refractory down, drop input
          wr_en  = 1'b1;
          wr_row = upd.refr_row;
          if (last) begin
            state_d = S_END;
          end else begin
            rd_en = 1'b1;
            idx_d = idx_nxt;
          end
        end else begin
          mul_en  = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // hold while a spike cannot be placed in the output register
        if (!upd.fire || out_free) begin
          wr_en = 1'b1;
          if (upd.fire) begin
            ov_d  = 1'b1;
            sp_d  = 5'(idx_q);
            tot_d = upd.tick_row.cnt;
            end_d = 1'b0;
          end
          if (last) begin
            state_d = S_END;
          end else begin
            rd_en   = 1'b1;
            idx_d   = idx_nxt;
            state_d = S_MUL;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          ov_d    = 1'b1;
          sp_d    = '0;
          tot_d   = '0;
          end_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      amt_q   <= '0;
      ov_q    <= 1'b0;
      sp_q    <= '0;
      tot_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      amt_q   <= amt_d;
      ov_q    <= ov_d;
      sp_q    <= sp_d;
      tot_q   <= tot_d;
      end_q   <= end_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign spiked_neuron_o = sp_q;
  assign spike_total_o   = tot_q;
  assign tick_end_o      = end_q;

  // A tick request keeps the input side busy in the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == lifl_pkg::OP_TICK) |=> in_stall_o)
    else $error("tick request did not start the neuron walk");

  // A spike result always carries a nonzero count
  a_spike_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tick_end_o |-> spike_total_o != '0)
    else $error("spike result with zero count");

  // Placing the end marker returns the sequencer to idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END) && out_free |=> !in_stall_o && out_valid_o && tick_end_o)
    else $error("end marker not issued on leaving the tick");

  // Rows are written only while a request is in progress
  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> in_stall_o)
    else $error("row write while idle");

endmodule
